// File: hw/rtl/rtd_pkg.sv
// Shared types, constants and digit helpers for the radix digit converter.
package rtd_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int MAX_DIGITS_DEF = 32;

  localparam int RADIX_BITS = 5;
  localparam int DIGIT_BITS = 4;
  localparam int CHAR_BITS  = 7;
  localparam int M_DATA_W   = 8;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'd48;  // '0'
  localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 7'd57;  // '9'
  localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 7'd65;  // 'A'
  localparam logic [CHAR_BITS-1:0] CHAR_UPPER_F = 7'd70;  // 'F'

  localparam logic [DIGIT_BITS-1:0] DEC_LIMIT = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_SEND
  } rtd_state_t;

  typedef struct packed {
    logic push;
    logic rd_en;
  } stack_cmd_t;

  // Out-of-range bases clamp to 2..16
  function automatic logic [RADIX_BITS-1:0] sat_radix(input logic [RADIX_BITS-1:0] r);
    logic [RADIX_BITS-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_BITS-1:0] glyph(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] res;
    if (d < DEC_LIMIT) res = CHAR_ZERO + CHAR_BITS'(d);
    else               res = CHAR_UPPER_A + CHAR_BITS'(d - DEC_LIMIT);
    return res;
  endfunction

endpackage

// File: hw/rtl/rtd_div_unit.sv
// Bit-serial restoring divider: one quotient bit per cycle, divisor up to 16.
module rtd_div_unit #(
  parameter int VALUE_BITS = rtd_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [VALUE_BITS-1:0]           dividend,
  input  logic [rtd_pkg::RADIX_BITS-1:0]  divisor,
  output logic                            done,
  output logic [VALUE_BITS-1:0]           quotient,
  output logic [rtd_pkg::DIGIT_BITS-1:0]  remainder
);
  import rtd_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [RADIX_BITS-1:0] dvs;
  logic [RADIX_BITS-1:0] trial;
  logic                  fits;

  // remainder stays below the divisor, so it fits in four bits
  assign trial = {remainder, quotient[VALUE_BITS-1]};
  assign fits  = (trial >= dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_BITS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[VALUE_BITS-2:0], fits};
      remainder <= fits ? DIGIT_BITS'(trial - dvs) : DIGIT_BITS'(trial);
    end
  end

endmodule

// File: hw/rtl/rtd_digit_stack.sv
// Remainder stack: one write port, one registered read port.
module rtd_digit_stack #(
  parameter int MAX_DIGITS = rtd_pkg::MAX_DIGITS_DEF
) (
  input  logic                            clk,
  input  rtd_pkg::stack_cmd_t             cmd,
  input  logic [$clog2(MAX_DIGITS)-1:0]   wr_addr,
  input  logic [rtd_pkg::DIGIT_BITS-1:0]  wr_data,
  input  logic [$clog2(MAX_DIGITS)-1:0]   rd_addr,
  output logic [rtd_pkg::DIGIT_BITS-1:0]  rd_data
);
  import rtd_pkg::*;

  logic [DIGIT_BITS-1:0] mem [MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (cmd.push) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/integer_to_radix_digits.sv
// Top level: integer to radix digit string converter.
//
//  channel  dir  fields (lsb first)                        transfer
//  s_*      in   value[VALUE_BITS], radix[5], zero pad      s_tvalid & s_tready
//  m_*      out  digit_char[7], zero pad; tlast=last_digit  m_tvalid & m_tready
//
// For each digit the bit-serial divider runs VALUE_BITS shift-subtract steps
// and then signals done; the digits are then popped from the stack, each
// through a read state and a send state. s_tready is high only while idle.
// Synchronous reset returns the sequencer to idle; the stack needs no clearing.
// Output stalls simply hold the current digit.
module integer_to_radix_digits #(
  parameter int VALUE_BITS = rtd_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = rtd_pkg::MAX_DIGITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  input  logic [((VALUE_BITS+rtd_pkg::RADIX_BITS+7)/8)*8-1:0] s_tdata, // value, radix
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  output logic [rtd_pkg::M_DATA_W-1:0]                  m_tdata,  // digit_char
  output logic                                          m_tlast
);
  import rtd_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int AW = $clog2(MAX_DIGITS);

  rtd_state_t state, state_next;

  logic [RADIX_BITS-1:0] base;
  logic [CW-1:0]         count;

  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [RADIX_BITS-1:0] div_divisor;
  logic [VALUE_BITS-1:0] quotient;
  logic [DIGIT_BITS-1:0] remainder;

  stack_cmd_t            stk_cmd;
  logic [CW-1:0]         rd_ptr;
  logic [DIGIT_BITS-1:0] rd_data;

  logic in_xfer;
  logic out_xfer;
  logic room;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;
  assign room     = (count < CW'(MAX_DIGITS));
  assign rd_ptr   = count - 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_DIV;
      ST_DIV:  if (div_done && quotient == '0) state_next = ST_READ;
      ST_READ: state_next = ST_SEND;
      ST_SEND: begin
        if (out_xfer) state_next = (count == '0) ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready      = 1'b0;
    m_tvalid      = 1'b0;
    div_start     = 1'b0;
    div_dividend  = quotient;
    div_divisor   = base;
    stk_cmd       = '0;
    case (state)
      ST_IDLE: begin
        s_tready     = 1'b1;
        div_start    = s_tvalid;
        div_dividend = s_tdata[VALUE_BITS-1:0];
        div_divisor  = sat_radix(s_tdata[VALUE_BITS +: RADIX_BITS]);
      end
      ST_DIV: begin
        // zero is still one digit: push first, stop when the quotient runs out
        div_start    = div_done && (quotient != '0);
        stk_cmd.push = div_done && room;
      end
      ST_READ: stk_cmd.rd_en = 1'b1;
      ST_SEND: m_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (in_xfer)          count <= '0;
      else if (stk_cmd.push) count <= count + 1'b1;
      else if (stk_cmd.rd_en) count <= rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) base <= sat_radix(s_tdata[VALUE_BITS +: RADIX_BITS]);
  end

  rtd_div_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  rtd_digit_stack #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_stack (
    .clk     (clk),
    .cmd     (stk_cmd),
    .wr_addr (count[AW-1:0]),
    .wr_data (remainder),
    .rd_addr (rd_ptr[AW-1:0]),
    .rd_data (rd_data)
  );

  assign m_tdata = {1'b0, glyph(rd_data)};
  assign m_tlast = (count == '0);

endmodule

// File: hw/rtl/rtd_checker.sv
// Port-level checks for the radix digit converter, bound to the top level.
module rtd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rtd_pkg::M_DATA_W-1:0]  m_tdata,
  input logic                          m_tlast
);
  import rtd_pkg::*;

  // only hex glyphs ever leave the block
  a_glyph_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[6:0] >= CHAR_ZERO && m_tdata[6:0] <= CHAR_NINE) ||
                  (m_tdata[6:0] >= CHAR_UPPER_A && m_tdata[6:0] <= CHAR_UPPER_F)))
    else $error("digit outside 0-9/A-F");

  // one item in flight: no input taken while digits are being sent
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while output pending");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
    else $error("not busy after input transfer");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("not idle after reset");

endmodule

bind integer_to_radix_digits rtd_checker u_rtd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
